// ===== rtl/zci_pkg.sv =====
// Package for the zero-crossing interpolator: field widths, codes, state type
// and the control structs shared between the sequencer and its units.
// Depends on nothing; every other file of the block uses it.
package zci_pkg;

  // Fixed field widths of the channels.
  localparam int DATA_W     = 32;
  localparam int IDX_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Defaults of the top-level parameters.
  localparam int NUM_VARS_DEF  = 8;
  localparam int FRAC_BITS_DEF = 16;

  // Reset values of the configuration registers.
  localparam logic [2:0] SEL_RST = 3'd0;
  localparam logic [1:0] DIR_RST = 2'b01;
  localparam logic [3:0] CNT_RST = 4'd8;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_NOT_STARTED = 2'd0,
    STATUS_NO_CROSS    = 2'd1,
    STATUS_CROSS       = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELECTED_VAR = 2'd0,
    CFG_DIRECTION    = 2'd1,
    CFG_ACTIVE_COUNT = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL_RD,
    ST_TEST,
    ST_P_GO,
    ST_P_WAIT,
    ST_Q_GO,
    ST_Q_WAIT,
    ST_EMIT_RD,
    ST_MAC_P,
    ST_MAC_Q,
    ST_MAC_SUM,
    ST_OUT
  } state_t;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic mul_en;    // register a new product
    logic acc_load;  // move the held product into the accumulator
  } mac_ctrl_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/zci_if.sv =====
// Channel interfaces of the zero-crossing interpolator: sample input,
// result output and configuration write. Depends on zci_pkg for widths.

interface zci_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [zci_pkg::DATA_W-1:0]    sample_value;
  logic        [zci_pkg::IDX_W-1:0]     var_index;

  modport source (output valid, output sample_value, output var_index, input ready);
  modport sink   (input valid, input sample_value, input var_index, output ready);
endinterface

interface zci_out_if;
  logic                                 valid;
  logic                                 ready;
  logic        [zci_pkg::STATUS_W-1:0]  status;
  logic        [zci_pkg::IDX_W-1:0]     out_index;
  logic signed [zci_pkg::DATA_W-1:0]    out_value;
  logic                                 last_of_run;

  modport source (output valid, output status, output out_index, output out_value,
                  output last_of_run, input ready);
  modport sink   (input valid, input status, input out_index, input out_value,
                  input last_of_run, output ready);
endinterface

interface zci_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [zci_pkg::CFG_IDX_W-1:0]        index;
  logic [zci_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/zci_store.sv =====
// Sample store: two banks of vector entries with a per-entry flag that tells
// which bank holds the current value. Depends on zci_pkg.
module zci_store #(
  parameter int NUM_VARS = zci_pkg::NUM_VARS_DEF,
  parameter int AW       = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [zci_pkg::DATA_W-1:0]  wr_data,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [zci_pkg::DATA_W-1:0]  prev_data,
  output logic signed [zci_pkg::DATA_W-1:0]  cur_data
);

  logic [zci_pkg::DATA_W-1:0] bank_a [NUM_VARS];
  logic [zci_pkg::DATA_W-1:0] bank_b [NUM_VARS];
  logic [NUM_VARS-1:0]        cur_b_r;
  logic [NUM_VARS-1:0]        va_r;
  logic [NUM_VARS-1:0]        vb_r;

  logic [zci_pkg::DATA_W-1:0] a_q_r;
  logic [zci_pkg::DATA_W-1:0] b_q_r;
  logic                       cur_b_q_r;
  logic                       va_q_r;
  logic                       vb_q_r;
  logic [zci_pkg::DATA_W-1:0] a_val;
  logic [zci_pkg::DATA_W-1:0] b_val;

  // A new sample goes into the bank that holds the previous value, so the old
  // current value becomes the previous one without a read.
  always_ff @(posedge clk) begin
    if (wr_en && !cur_b_r[wr_addr]) begin
      bank_b[wr_addr] <= wr_data;
    end
    if (wr_en && cur_b_r[wr_addr]) begin
      bank_a[wr_addr] <= wr_data;
    end
  end

  // Bank flags and valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_b_r <= '0;
      va_r    <= '0;
      vb_r    <= '0;
    end else if (wr_en) begin
      cur_b_r[wr_addr] <= !cur_b_r[wr_addr];
      if (cur_b_r[wr_addr]) begin
        va_r[wr_addr] <= 1'b1;
      end else begin
        vb_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Registered read of both banks at one address.
  always_ff @(posedge clk) begin
    a_q_r     <= bank_a[rd_addr];
    b_q_r     <= bank_b[rd_addr];
    cur_b_q_r <= cur_b_r[rd_addr];
    va_q_r    <= va_r[rd_addr];
    vb_q_r    <= vb_r[rd_addr];
  end

  // Sort the two read words into previous and current.
  always_comb begin
    a_val     = va_q_r ? a_q_r : '0;
    b_val     = vb_q_r ? b_q_r : '0;
    cur_data  = cur_b_q_r ? b_val : a_val;
    prev_data = cur_b_q_r ? a_val : b_val;
  end

endmodule

// ===== rtl/zci_div.sv =====
// Restoring serial divider: floor(num * 2^FRAC_BITS / den) for num <= den,
// one quotient bit per cycle. Depends on zci_pkg for the status struct.
module zci_div #(
  parameter int FRAC_BITS = zci_pkg::FRAC_BITS_DEF,
  parameter int QW        = FRAC_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [31:0]              num,
  input  logic [31:0]              den,
  output logic [QW-1:0]            quot,
  output zci_pkg::div_stat_t       stat
);

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [32:0]   r_r;
  logic [31:0]   d_r;
  logic [QW-1:0] quot_r;
  logic [CW-1:0] cnt_r;
  logic          first_r;
  logic          busy_r;
  logic          done_r;

  logic [32:0]   t;
  logic          ge;

  // One compare and subtract step; the first step takes the integer bit.
  always_comb begin
    t  = first_r ? r_r : {r_r[31:0], 1'b0};
    ge = (t >= {1'b0, d_r});
  end

  // Control state of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= CW'(FRAC_BITS);
      end else if (busy_r) begin
        first_r <= 1'b0;
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      r_r    <= {1'b0, num};
      d_r    <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      r_r    <= ge ? (t - {1'b0, d_r}) : t;
      quot_r <= {quot_r[QW-2:0], ge};
    end
  end

  assign quot      = quot_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/zci_mac.sv =====
// Multiply-accumulate unit: one signed multiplier with a product register and
// an accumulator, used twice per interpolated value. Depends on zci_pkg.
module zci_mac #(
  parameter int FRAC_BITS = zci_pkg::FRAC_BITS_DEF,
  parameter int QW        = FRAC_BITS + 1
) (
  input  logic                               clk,
  input  zci_pkg::mac_ctrl_t                 ctrl,
  input  logic [QW-1:0]                      coef,
  input  logic signed [zci_pkg::DATA_W-1:0]  sample,
  output logic signed [63:0]                 sum
);

  localparam int PW = QW + zci_pkg::DATA_W + 1;

  logic signed [QW:0]   coef_s;
  logic signed [PW-1:0] prod_full;
  logic signed [63:0]   prod_r;
  logic signed [63:0]   acc_r;

  // Unsigned coefficient times signed sample.
  always_comb begin
    coef_s    = $signed({1'b0, coef});
    prod_full = coef_s * sample;
  end

  // Product register, then the accumulator.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= 64'(prod_full);
    end
    if (ctrl.acc_load) begin
      acc_r <= prod_r;
    end
  end

  assign sum = acc_r + prod_r;

endmodule

// ===== rtl/zero_crossing_interpolator.sv =====
// Top level of the zero-crossing interpolator: configuration registers and
// the sequencer over the sample store, serial divider and MAC unit.
// Depends on zci_pkg, zci_if, zci_store, zci_div and zci_mac.
//
//   channel  | interface  | role   | payload
//   in_if    | zci_in_if  | sink   | sample_value, var_index
//   out_if   | zci_out_if | source | status, out_index, out_value, last_of_run
//   cfg_if   | zci_cfg_if | sink   | index, data (always ready)
//
// A closing sample with no crossing, or the first vector, gives one result: the
// first vector straight from idle, the other case after a store read and the
// crossing test. A crossing makes two passes through the one-bit-per-cycle
// divider, then for each of n variables a store read, two products on the
// single multiplier, the sum and an output. in_if is not ready until the last
// result of a vector is taken; a stalled out_if holds the result. Reset is
// synchronous and clears the store through valid bits at once.
module zero_crossing_interpolator #(
  parameter int NUM_VARS  = zci_pkg::NUM_VARS_DEF,
  parameter int FRAC_BITS = zci_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  zci_in_if.sink    in_if,
  zci_out_if.source out_if,
  zci_cfg_if.sink   cfg_if
);

  localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int QW = FRAC_BITS + 1;
  localparam logic signed [31:0] ONE_VAL = 32'(64'd1 << FRAC_BITS);

  zci_pkg::state_t state_r, state_nxt;

  logic [2:0]  sel_r;
  logic [1:0]  dir_r;
  logic [3:0]  cnt_r;
  logic        started_r;
  logic [31:0] ay0_r;
  logic [31:0] ay1_r;
  logic [31:0] d_r;
  logic        up_r;
  logic [QW-1:0] p_r;
  logic [QW-1:0] q_r;
  logic [2:0]  i_r;

  zci_pkg::status_t out_status_r;
  logic [2:0]       out_idx_r;
  logic [31:0]      out_val_r;
  logic             out_last_r;

  logic [3:0]  n_eff;
  logic        in_acc;
  logic        idx_ok;
  logic        idx_last;
  logic        sel_ok;
  logic signed [31:0] y0;
  logic signed [31:0] y1;
  logic        y0_le0, y0_ge0, crossing;

  logic        mem_wr;
  logic [AW-1:0] rd_addr;
  logic signed [31:0] prev_data;
  logic signed [31:0] cur_data;
  logic        div_start;
  logic [31:0] div_num;
  logic [QW-1:0] div_quot;
  zci_pkg::div_stat_t div_stat;
  zci_pkg::mac_ctrl_t mac_ctrl;
  logic [QW-1:0] mac_coef;
  logic signed [31:0] mac_sample;
  logic signed [63:0] mac_sum;

  // Effective vector length and checks on the incoming sample.
  always_comb begin
    if (cnt_r == 4'd0) begin
      n_eff = 4'd1;
    end else if (32'(cnt_r) > NUM_VARS) begin
      n_eff = 4'(NUM_VARS);
    end else begin
      n_eff = cnt_r;
    end
    in_acc   = in_if.valid && in_if.ready;
    idx_ok   = ({1'b0, in_if.var_index} < n_eff);
    idx_last = ({1'b0, in_if.var_index} == (n_eff - 4'd1));
    sel_ok   = (32'(sel_r) < NUM_VARS);
  end

  // Crossing test on the selected variable.
  always_comb begin
    y0       = sel_ok ? prev_data : '0;
    y1       = sel_ok ? cur_data : '0;
    y0_le0   = y0[31] || (y0 == '0);
    y0_ge0   = !y0[31];
    crossing = (!dir_r[1] && y0_le0 && !y1[31] && (y1 != '0)) ||
               ((dir_r[1] || (dir_r == 2'b00)) && y0_ge0 && y1[31]);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      zci_pkg::ST_IDLE: begin
        if (in_acc && idx_ok && idx_last) begin
          state_nxt = started_r ? zci_pkg::ST_SEL_RD : zci_pkg::ST_OUT;
        end
      end
      zci_pkg::ST_SEL_RD:  state_nxt = zci_pkg::ST_TEST;
      zci_pkg::ST_TEST:    state_nxt = crossing ? zci_pkg::ST_P_GO : zci_pkg::ST_OUT;
      zci_pkg::ST_P_GO:    state_nxt = zci_pkg::ST_P_WAIT;
      zci_pkg::ST_P_WAIT: begin
        if (div_stat.done) begin
          state_nxt = zci_pkg::ST_Q_GO;
        end
      end
      zci_pkg::ST_Q_GO:    state_nxt = zci_pkg::ST_Q_WAIT;
      zci_pkg::ST_Q_WAIT: begin
        if (div_stat.done) begin
          state_nxt = zci_pkg::ST_EMIT_RD;
        end
      end
      zci_pkg::ST_EMIT_RD: state_nxt = zci_pkg::ST_MAC_P;
      zci_pkg::ST_MAC_P:   state_nxt = zci_pkg::ST_MAC_Q;
      zci_pkg::ST_MAC_Q:   state_nxt = zci_pkg::ST_MAC_SUM;
      zci_pkg::ST_MAC_SUM: state_nxt = zci_pkg::ST_OUT;
      zci_pkg::ST_OUT: begin
        if (out_if.ready) begin
          state_nxt = out_last_r ? zci_pkg::ST_IDLE : zci_pkg::ST_EMIT_RD;
        end
      end
      default:             state_nxt = zci_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs to the store, divider and MAC unit.
  always_comb begin
    mem_wr            = (state_r == zci_pkg::ST_IDLE) && in_acc && idx_ok;
    div_start         = (state_r == zci_pkg::ST_P_GO) || (state_r == zci_pkg::ST_Q_GO);
    div_num           = (state_r == zci_pkg::ST_P_GO) ? ay1_r : ay0_r;
    mac_ctrl.mul_en   = (state_r == zci_pkg::ST_MAC_P) || (state_r == zci_pkg::ST_MAC_Q);
    mac_ctrl.acc_load = (state_r == zci_pkg::ST_MAC_Q);
    mac_coef          = (state_r == zci_pkg::ST_MAC_P) ? p_r : q_r;
    mac_sample        = (state_r == zci_pkg::ST_MAC_P) ? prev_data : cur_data;
    if (state_r inside {zci_pkg::ST_EMIT_RD, zci_pkg::ST_MAC_P, zci_pkg::ST_MAC_Q}) begin
      rd_addr = AW'(i_r);
    end else begin
      rd_addr = AW'(sel_r);
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= zci_pkg::ST_IDLE;
      sel_r     <= zci_pkg::SEL_RST;
      dir_r     <= zci_pkg::DIR_RST;
      cnt_r     <= zci_pkg::CNT_RST;
      started_r <= 1'b0;
      i_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          zci_pkg::CFG_SELECTED_VAR: sel_r <= cfg_if.data[2:0];
          zci_pkg::CFG_DIRECTION:    dir_r <= cfg_if.data[1:0];
          zci_pkg::CFG_ACTIVE_COUNT: cnt_r <= cfg_if.data;
          default:                   ;
        endcase
      end
      if (state_r == zci_pkg::ST_IDLE && in_acc && idx_ok && idx_last) begin
        started_r <= 1'b1;
      end
      if (state_r == zci_pkg::ST_Q_WAIT) begin
        i_r <= '0;
      end else if (state_r == zci_pkg::ST_OUT && out_if.ready && !out_last_r) begin
        i_r <= i_r + 3'd1;
      end
    end
  end

  // Datapath registers: magnitudes, coefficients and the output result.
  always_ff @(posedge clk) begin
    if (state_r == zci_pkg::ST_TEST) begin
      ay0_r <= y0[31] ? 32'(-y0) : 32'(y0);
      ay1_r <= y1[31] ? 32'(-y1) : 32'(y1);
      d_r   <= (y0[31] ? 32'(-y0) : 32'(y0)) + (y1[31] ? 32'(-y1) : 32'(y1));
      up_r  <= (y1 > y0);
    end
    if (state_r == zci_pkg::ST_P_WAIT && div_stat.done) begin
      p_r <= div_quot;
    end
    if (state_r == zci_pkg::ST_Q_WAIT && div_stat.done) begin
      q_r <= div_quot;
    end
    if (state_r == zci_pkg::ST_IDLE && in_acc && idx_ok && idx_last && !started_r) begin
      out_status_r <= zci_pkg::STATUS_NOT_STARTED;
      out_idx_r    <= sel_r;
      out_val_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (state_r == zci_pkg::ST_TEST && !crossing) begin
      out_status_r <= zci_pkg::STATUS_NO_CROSS;
      out_idx_r    <= sel_r;
      out_val_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (state_r == zci_pkg::ST_MAC_SUM) begin
      out_status_r <= zci_pkg::STATUS_CROSS;
      out_idx_r    <= i_r;
      if (i_r == sel_r) begin
        out_val_r <= up_r ? ONE_VAL : -ONE_VAL;
      end else begin
        out_val_r <= mac_sum[FRAC_BITS +: 32];
      end
      out_last_r   <= ({1'b0, i_r} == (n_eff - 4'd1));
    end
  end

  // Channel outputs.
  assign in_if.ready        = (state_r == zci_pkg::ST_IDLE);
  assign cfg_if.ready       = 1'b1;
  assign out_if.valid       = (state_r == zci_pkg::ST_OUT);
  assign out_if.status      = out_status_r;
  assign out_if.out_index   = out_idx_r;
  assign out_if.out_value   = out_val_r;
  assign out_if.last_of_run = out_last_r;

  zci_store #(
    .NUM_VARS (NUM_VARS),
    .AW       (AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (mem_wr),
    .wr_addr   (AW'(in_if.var_index)),
    .wr_data   (in_if.sample_value),
    .rd_addr   (rd_addr),
    .prev_data (prev_data),
    .cur_data  (cur_data)
  );

  zci_div #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  zci_mac #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .coef   (mac_coef),
    .sample (mac_sample),
    .sum    (mac_sum)
  );

  // A single-result vector always closes its run.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zci_pkg::ST_OUT) && (out_status_r != zci_pkg::STATUS_CROSS) |-> out_last_r)
    else $error("single result without last_of_run");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == zci_pkg::ST_P_WAIT) || (state_r == zci_pkg::ST_Q_WAIT))
    else $error("divider finished outside a wait state");

  // The first closed vector is reported as not started.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |->
      (state_r == zci_pkg::ST_OUT) && (out_status_r == zci_pkg::STATUS_NOT_STARTED))
    else $error("first vector not reported as not started");

  // The last interpolated value belongs to the last active variable.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zci_pkg::ST_OUT) && (out_status_r == zci_pkg::STATUS_CROSS) && out_last_r
      |-> ({1'b0, out_idx_r} == (n_eff - 4'd1)))
    else $error("crossing run closed at the wrong variable");

endmodule

// ===== tb/zero_crossing_interpolator_test.sv =====
// Self-checking testbench for zero_crossing_interpolator: drives samples and
// register writes, predicts every section point and checks them in order.
// Depends on zci_pkg, the channel interfaces in zci_if and the top level.
module zero_crossing_interpolator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VARS          = zci_pkg::NUM_VARS_DEF;
  localparam int FRAC          = zci_pkg::FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS  = 380;
  localparam int PHASE_ITEMS   = 40;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam logic [zci_pkg::DATA_W-1:0] ONE_Q = 32'(1) << FRAC;

  // Extreme vectors for the opening transactions: the second one crosses
  // upward on variable 0 from the most negative to the most positive value.
  localparam logic [zci_pkg::DATA_W-1:0] OPEN_VEC [8] = '{
    32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0000,
    32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'h0001_0000
  };
  localparam logic [zci_pkg::DATA_W-1:0] CROSS_VEC [8] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000, 32'hFFFF_FFFF,
    32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h1234_5678
  };

  typedef struct {
    logic [zci_pkg::STATUS_W-1:0] status;
    logic [zci_pkg::IDX_W-1:0]    index;
    logic [zci_pkg::DATA_W-1:0]   value;
    logic                         last;
  } point_t;

  // Predictor of the section points, with its own copy of the vectors and
  // registers, plus the queue of points still to come from the block.
  class section_predictor;
    logic [zci_pkg::DATA_W-1:0] prev_vec [VARS];
    logic [zci_pkg::DATA_W-1:0] cur_vec [VARS];
    bit                         started;
    logic [zci_pkg::IDX_W-1:0]  sel;
    logic [1:0]                 dir_code;
    logic [3:0]                 count;
    point_t                     expected_points [$];
    int                         mismatches;

    function new();
      foreach (prev_vec[i]) begin
        prev_vec[i] = '0;
        cur_vec[i]  = '0;
      end
      started    = 1'b0;
      sel        = zci_pkg::SEL_RST;
      dir_code   = zci_pkg::DIR_RST;
      count      = zci_pkg::CNT_RST;
      mismatches = 0;
    endfunction

    // A count of zero acts as one; anything above the store size is clamped.
    function int active_n();
      if (count == 0) return 1;
      if (count > VARS) return VARS;
      return count;
    endfunction

    function void write_reg(zci_pkg::cfg_reg_t r, logic [zci_pkg::CFG_DATA_W-1:0] d);
      case (r)
        zci_pkg::CFG_SELECTED_VAR: sel = d[zci_pkg::IDX_W-1:0];
        zci_pkg::CFG_DIRECTION:    dir_code = d[1:0];
        zci_pkg::CFG_ACTIVE_COUNT: count = d;
        default: ;
      endcase
    endfunction

    function void push_point(zci_pkg::status_t st, logic [zci_pkg::IDX_W-1:0] idx,
                             logic [zci_pkg::DATA_W-1:0] val, logic last);
      point_t pt;
      pt.status = st;
      pt.index  = idx;
      pt.value  = val;
      pt.last   = last;
      expected_points.push_back(pt);
    endfunction

    // Note one accepted sample and queue the points it causes.
    function void note_sample(logic [zci_pkg::DATA_W-1:0] value,
                              logic [zci_pkg::IDX_W-1:0] idx);
      int                         n;
      longint                     y0, y1, d, p, q, acc;
      bit                         up_ok, down_ok, crossing;
      logic [zci_pkg::DATA_W-1:0] v;
      n = active_n();
      if (idx >= n) return;
      prev_vec[idx] = cur_vec[idx];
      cur_vec[idx]  = value;
      if (idx != n - 1) return;

      if (!started) begin
        started = 1'b1;
        push_point(zci_pkg::STATUS_NOT_STARTED, sel, '0, 1'b1);
        return;
      end

      // Direction codes: 01 upward only, 00 either, 11 and 10 downward only.
      y0       = longint'($signed(prev_vec[sel]));
      y1       = longint'($signed(cur_vec[sel]));
      up_ok    = !dir_code[1];
      down_ok  = (dir_code != 2'b01);
      crossing = (up_ok && y0 <= 0 && y1 > 0) || (down_ok && y0 >= 0 && y1 < 0);
      if (!crossing) begin
        push_point(zci_pkg::STATUS_NO_CROSS, sel, '0, 1'b1);
        return;
      end

      // Weights toward the crossing point, then each variable interpolated
      // with the result floored to the Q16.16 grid.
      d = (y1 > y0) ? y1 - y0 : y0 - y1;
      p = ((y1 < 0 ? -y1 : y1) << FRAC) / d;
      q = ((y0 < 0 ? -y0 : y0) << FRAC) / d;
      for (int i = 0; i < n; i++) begin
        if (i == sel) begin
          v = (y1 > y0) ? ONE_Q : -ONE_Q;
        end else begin
          acc = p * longint'($signed(prev_vec[i])) + q * longint'($signed(cur_vec[i]));
          v   = acc[FRAC +: zci_pkg::DATA_W];
        end
        push_point(zci_pkg::STATUS_CROSS, zci_pkg::IDX_W'(i), v, (i == n - 1));
      end
    endfunction

    // Compare one accepted result transaction with the oldest expected point.
    function void check_point(logic [zci_pkg::STATUS_W-1:0] st,
                              logic [zci_pkg::IDX_W-1:0] idx,
                              logic [zci_pkg::DATA_W-1:0] val, logic last);
      point_t pt;
      if (expected_points.size() == 0) begin
        $error("unexpected result: status %0d out_index %0d out_value %h last_of_run %0b",
               st, idx, val, last);
        mismatches++;
        return;
      end
      pt = expected_points.pop_front();
      if (st !== pt.status) begin
        $error("status: expected %0d, actual %0d", pt.status, st);
        mismatches++;
      end
      if (idx !== pt.index) begin
        $error("out_index: expected %0d, actual %0d", pt.index, idx);
        mismatches++;
      end
      if (val !== pt.value) begin
        $error("out_value: expected %h, actual %h", pt.value, val);
        mismatches++;
      end
      if (last !== pt.last) begin
        $error("last_of_run: expected %0b, actual %0b", pt.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  zci_in_if  in_ch ();
  zci_out_if out_ch ();
  zci_cfg_if cfg_ch ();

  zero_crossing_interpolator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  section_predictor book;
  bit               quiet;
  bit               hold_req;
  int               random_items;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed limit on the whole run.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL zero_crossing_interpolator");
    $finish;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 19);
  endfunction

  // Sample values; the biased form puts the selected variable near zero in half
  // of the draws, with a random sign, so that crossings come often.
  function automatic logic [zci_pkg::DATA_W-1:0] draw_value(bit near_zero);
    if (near_zero) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return zci_pkg::DATA_W'($urandom_range(1, 32'h7_FFFF));
        2: return -zci_pkg::DATA_W'($urandom_range(1, 32'h7_FFFF));
        3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: return $urandom();
      endcase
    end
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return zci_pkg::DATA_W'($urandom_range(0, 32'h3_FFFF));
      4: return -zci_pkg::DATA_W'($urandom_range(1, 32'h3_FFFF));
      default: return $urandom();
    endcase
  endfunction

  // Offer one sample transaction after a random gap and wait for acceptance.
  task automatic send_sample(logic [zci_pkg::DATA_W-1:0] value,
                             logic [zci_pkg::IDX_W-1:0] idx);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= value;
    in_ch.var_index    <= idx;
    do @(posedge clk); while (!in_ch.ready);
    if (idx < book.active_n()) random_items++;
    book.note_sample(value, idx);
  endtask

  // One register write transaction.
  task automatic write_reg(zci_pkg::cfg_reg_t r, logic [zci_pkg::CFG_DATA_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    book.write_reg(r, d);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every expected point has arrived and the block is idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, and one long hold-off when requested.
  task automatic take_results();
    int gap;
    forever begin
      gap = draw_gap();
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      book.check_point(out_ch.status, out_ch.out_index, out_ch.out_value, out_ch.last_of_run);
    end
  endtask

  // One random phase: pick a setting, then mostly whole vectors with some
  // stray, partial and out-of-range samples mixed in.
  task automatic run_phase(int k);
    logic [zci_pkg::IDX_W-1:0] s;
    logic [1:0]                dcode;
    logic [3:0]                cnt;
    int                        start, n, a, b;
    case (k)
      0: begin s = 3'd0; dcode = 2'b01; cnt = 4'd8; end
      1: begin s = 3'd7; dcode = 2'b11; cnt = 4'd1; end
      2: begin s = 3'd3; dcode = 2'b00; cnt = 4'd15; end
      3: begin s = 3'd5; dcode = 2'b10; cnt = 4'd0; end
      4: begin s = 3'd7; dcode = 2'b00; cnt = 4'd8; end
      default: begin
        s     = zci_pkg::IDX_W'($urandom_range(0, 7));
        dcode = 2'($urandom_range(0, 3));
        cnt   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
      end
    endcase
    write_reg(zci_pkg::CFG_SELECTED_VAR, {1'($urandom_range(0, 1)), s});
    write_reg(zci_pkg::CFG_DIRECTION, {2'($urandom_range(0, 3)), dcode});
    write_reg(zci_pkg::CFG_ACTIVE_COUNT, cnt);

    // The wide phase with crossings is where the result side holds off.
    if (k == 2) hold_req = 1'b1;

    n     = book.active_n();
    start = random_items;
    while (random_items - start < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        7: send_sample(draw_value(0), zci_pkg::IDX_W'($urandom_range(0, 7)));
        8: begin
          a = $urandom_range(0, n - 1);
          b = $urandom_range(a, n - 1);
          for (int i = a; i <= b; i++) begin
            send_sample(draw_value(i == s), zci_pkg::IDX_W'(i));
          end
        end
        9: begin
          if (n < VARS) begin
            send_sample(draw_value(0), zci_pkg::IDX_W'($urandom_range(n, VARS - 1)));
          end else begin
            send_sample(draw_value(0), zci_pkg::IDX_W'($urandom_range(0, 7)));
          end
        end
        default: begin
          for (int i = 0; i < n; i++) send_sample(draw_value(i == s), zci_pkg::IDX_W'(i));
        end
      endcase
    end
  endtask

  // Main sequence: reset, directed transactions, random phases, final check.
  initial begin
    int phase;
    in_ch.valid        <= 1'b0;
    in_ch.sample_value <= '0;
    in_ch.var_index    <= '0;
    out_ch.ready       <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= zci_pkg::CFG_SELECTED_VAR;
    cfg_ch.data        <= '0;
    rst_n              <= 1'b0;
    book     = new();
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    fork
      take_results();
    join_none

    // First vector after reset, then an upward crossing between extremes.
    for (int i = 0; i < VARS; i++) send_sample(OPEN_VEC[i], zci_pkg::IDX_W'(i));
    for (int i = 0; i < VARS; i++) send_sample(CROSS_VEC[i], zci_pkg::IDX_W'(i));

    // Count zero acts as one and the selected variable lies outside the
    // vector; its stored values still cross upward, with either direction allowed.
    settle();
    write_reg(zci_pkg::CFG_SELECTED_VAR, 4'd2);
    write_reg(zci_pkg::CFG_DIRECTION, 4'b0000);
    write_reg(zci_pkg::CFG_ACTIVE_COUNT, 4'd0);
    send_sample(32'h0003_8000, 3'd0);
    send_sample(32'h7FFF_FFFF, 3'd5);
    send_sample(32'hFFFD_0000, 3'd0);

    // Direction pattern 10 behaves as downward only, so no crossing.
    settle();
    write_reg(zci_pkg::CFG_DIRECTION, 4'b0010);
    send_sample(32'h8000_0000, 3'd0);

    // Random phases through several settings.
    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      run_phase(phase);
      phase++;
    end

    settle();
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("PASS zero_crossing_interpolator");
    end else begin
      $display("FAIL zero_crossing_interpolator");
    end
    $finish;
  end

endmodule

// ===== zero_crossing_interpolator.f =====
rtl/zci_pkg.sv
rtl/zci_if.sv
rtl/zci_store.sv
rtl/zci_div.sv
rtl/zci_mac.sv
rtl/zero_crossing_interpolator.sv
tb/zero_crossing_interpolator_test.sv
